FILE: rtl/ccds_pkg.sv
// shared types and constants of the curve center distance sorter
package ccds_pkg;

  // field widths fixed by the item format
  localparam int PT_W   = 13;
  localparam int KEY_W  = 15;
  localparam int ORD_W  = 4;
  localparam int COLS_W = 12;

  // center column sits this far right of the image middle
  localparam int CenterOffset = 50;

  // at most this many results leave per frame
  localparam int ResultLimit = 16;

  // default image width after reset
  localparam logic [COLS_W-1:0] COLS_RESET = 12'd640;

  // one stored entry: distance key and arrival order
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ORD_W-1:0] order;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_WALK,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/curve_center_distance_sorter_unit.sv
// curve center distance sorter: memory based stable insertion sort of lane curves
//
// Usage: one curve per input beat (four control-point x values and a last flag),
// accepted at a clock edge with start high and busy low. Each curve gets the key
// |x0+x1+x2+x3 - 4*(image_cols/2 + 50)| and is inserted in ascending key order into
// a one-port-write, one-port-read synchronous memory; equal keys keep arrival order.
// An insertion reads one stored entry per cycle, moving it up one place while its key
// is larger, and busy stays high until the new curve is written. A curve that finds
// the store full is dropped and sets the overflow flag; busy stays low unless that
// curve is marked last. On the curve marked last the block then reads the store
// nearest first, one entry per cycle, and emits min(stored, 16) result beats on
// consecutive cycles, each marked by out_strobe for one cycle; each beat is the
// registered read data of the store.
// The receiver cannot hold results off. busy stays high until the final read is issued;
// the final beat appears in the first cycle with busy low, and the frame count and
// overflow flag are cleared by then.
// Reset (synchronous, rst_n low) empties the store logically, clears overflow and sets
// image_cols to 640; the memory itself needs no clearing. cfg_we writes image_cols
// and is meant only while the block is idle.
module curve_center_distance_sorter_unit #(
  parameter int MAX_CURVES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [ccds_pkg::COLS_W-1:0]    cfg_data,
  // curve input
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ccds_pkg::PT_W-1:0] in_point0_x,
  input  logic signed [ccds_pkg::PT_W-1:0] in_point1_x,
  input  logic signed [ccds_pkg::PT_W-1:0] in_point2_x,
  input  logic signed [ccds_pkg::PT_W-1:0] in_point3_x,
  input  logic                           in_last_curve,
  // sorted results
  output logic                           out_strobe,
  output logic [ccds_pkg::ORD_W-1:0]     out_curve_index,
  output logic [ccds_pkg::KEY_W-1:0]     out_distance_key,
  output logic                           out_top_two,
  output logic                           out_overflow,
  output logic                           out_last_result
);

  localparam int IDX_W   = $clog2(MAX_CURVES);
  localparam int CNT_W   = $clog2(MAX_CURVES + 1);
  localparam int OUT_LIM = (MAX_CURVES < ccds_pkg::ResultLimit) ?
                           MAX_CURVES : ccds_pkg::ResultLimit;

  // sorted store
  ccds_pkg::entry_t mem [MAX_CURVES];

  ccds_pkg::state_t                state_r, state_nxt;
  logic [ccds_pkg::COLS_W-1:0]     cols_r, cols_nxt;
  logic [ccds_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic                            last_r, last_nxt;
  logic [IDX_W-1:0]                pos_r, pos_nxt;
  logic [IDX_W-1:0]                k_r, k_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            strobe_r, strobe_nxt;
  logic                            top_r, top_nxt;
  logic                            ovf_out_r, ovf_out_nxt;
  logic                            last_res_r, last_res_nxt;
  ccds_pkg::entry_t                rd_data_r;

  logic                            mem_we;
  logic [IDX_W-1:0]                wr_addr;
  ccds_pkg::entry_t                wr_data;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;

  logic signed [15:0]              sum_s;
  logic [ccds_pkg::COLS_W-1:0]     cx_u;
  logic signed [15:0]              diff_s;
  logic [15:0]                     abs_u;
  logic [ccds_pkg::KEY_W-1:0]      key_calc;
  logic [CNT_W-1:0]                n_res;
  logic [CNT_W-1:0]                k_ext;
  ccds_pkg::entry_t                new_entry;

  // distance key of the incoming curve
  always_comb begin
    sum_s = 16'(in_point0_x) + 16'(in_point1_x) + 16'(in_point2_x) + 16'(in_point3_x);
    cx_u  = {1'b0, cols_r[ccds_pkg::COLS_W-1:1]} +
            ccds_pkg::COLS_W'(ccds_pkg::CenterOffset);
    diff_s = sum_s - $signed({2'b00, cx_u, 2'b00});
    abs_u  = diff_s[15] ? 16'(-diff_s) : 16'(diff_s);
    key_calc = abs_u[ccds_pkg::KEY_W-1:0];
  end

  // frame bookkeeping
  assign n_res     = (count_r < CNT_W'(OUT_LIM)) ? count_r : CNT_W'(OUT_LIM);
  assign k_ext     = CNT_W'(k_r);
  assign new_entry = '{key: key_r, order: ccds_pkg::ORD_W'(count_r)};

  // sequencer: insertion walk and result readout
  always_comb begin
    state_nxt    = state_r;
    cols_nxt     = cols_r;
    key_nxt      = key_r;
    last_nxt     = last_r;
    pos_nxt      = pos_r;
    k_nxt        = k_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    strobe_nxt   = 1'b0;
    top_nxt      = top_r;
    ovf_out_nxt  = ovf_out_r;
    last_res_nxt = last_res_r;
    mem_we       = 1'b0;
    wr_addr      = pos_r;
    wr_data      = new_entry;
    rd_en        = 1'b0;
    rd_addr      = pos_r - IDX_W'(1);

    if (cfg_we) begin
      cols_nxt = cfg_data;
    end

    unique case (state_r)
      ccds_pkg::ST_IDLE: begin
        if (start) begin
          key_nxt  = key_calc;
          last_nxt = in_last_curve;
          pos_nxt  = IDX_W'(count_r);
          k_nxt    = '0;
          if (count_r == CNT_W'(MAX_CURVES)) begin
            // store full: drop this curve
            ovf_nxt   = 1'b1;
            state_nxt = in_last_curve ? ccds_pkg::ST_EMIT : ccds_pkg::ST_IDLE;
          end else begin
            state_nxt = ccds_pkg::ST_SEEK;
          end
        end
      end
      ccds_pkg::ST_SEEK: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = last_r ? ccds_pkg::ST_EMIT : ccds_pkg::ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ccds_pkg::ST_WALK;
        end
      end
      ccds_pkg::ST_WALK: begin
        mem_we = 1'b1;
        if (rd_data_r.key > key_r) begin
          // move the larger entry up one place, look one lower
          wr_data = rd_data_r;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = ccds_pkg::ST_SEEK;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_r - IDX_W'(2);
          end
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = last_r ? ccds_pkg::ST_EMIT : ccds_pkg::ST_IDLE;
        end
      end
      ccds_pkg::ST_EMIT: begin
        rd_en        = 1'b1;
        rd_addr      = k_r;
        strobe_nxt   = 1'b1;
        top_nxt      = (k_ext < CNT_W'(2));
        ovf_out_nxt  = ovf_r;
        last_res_nxt = (k_ext == n_res - CNT_W'(1));
        if (k_ext == n_res - CNT_W'(1)) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ccds_pkg::ST_IDLE;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ccds_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ccds_pkg::ST_IDLE;
      cols_r   <= ccds_pkg::COLS_RESET;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cols_r   <= cols_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    top_r      <= top_nxt;
    ovf_out_r  <= ovf_out_nxt;
    last_res_r <= last_res_nxt;
  end

  // store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // store read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // ports
  assign busy             = (state_r != ccds_pkg::ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_curve_index  = rd_data_r.order;
  assign out_distance_key = rd_data_r.key;
  assign out_top_two      = top_r;
  assign out_overflow     = ovf_out_r;
  assign out_last_result  = last_res_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CURVES))
    else $error("curve count above capacity");

  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same entry");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> $past(state_r == ccds_pkg::ST_EMIT))
    else $error("result beat without readout");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last_result) |-> (count_r == '0 && !ovf_r))
    else $error("frame state not cleared after final beat");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccds_pkg::ST_EMIT) |-> (count_r != '0))
    else $error("readout of an empty store");

endmodule
